// File: hdl/cgr_pkg.sv
package cgr_pkg;

	// Table geometry
	localparam int MAX_KEYS = 16;
	localparam int IDX_W    = $clog2(MAX_KEYS);
	localparam int CNT_W    = 5;

	// Field widths
	localparam int MODE_W   = 2;
	localparam int TPT_W    = 18;
	localparam int TIME_W   = 17;
	localparam int COLOR_W  = 32;
	localparam int KIDX_W   = 4;
	localparam int STAT_W   = 2;
	localparam int FRAC_W   = 16;
	localparam int KEY_W    = TIME_W + COLOR_W;

	localparam logic [TIME_W-1:0]  ONE_Q16      = TIME_W'(65536);
	localparam logic [COLOR_W-1:0] BLACK_OPAQUE = 32'h0000_00FF;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_EVAL   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_BAD_INDEX = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	// Clamp a signed Q1.16 time to the range 0 .. 1.0.
	function automatic logic [TIME_W-1:0] sat_time(input logic signed [TPT_W-1:0] raw);
		logic [TIME_W-1:0] res;
		begin
			if (raw[TPT_W-1]) begin
				res = '0;
			end else if (raw[TPT_W-2:0] > ONE_Q16) begin
				res = ONE_Q16;
			end else begin
				res = raw[TIME_W-1:0];
			end
			return res;
		end
	endfunction

endpackage

// File: hdl/cgr_in_if.sv
interface cgr_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [cgr_pkg::MODE_W-1:0]           mode;
	logic signed [cgr_pkg::TPT_W-1:0]     time_point;
	logic [cgr_pkg::COLOR_W-1:0]          color_in;
	logic [cgr_pkg::KIDX_W-1:0]           key_index;

	modport source (output valid, mode, time_point, color_in, key_index, input ready);
	modport sink   (input valid, mode, time_point, color_in, key_index, output ready);
endinterface

// File: hdl/cgr_out_if.sv
interface cgr_out_if;
	logic                           valid;
	logic                           ready;
	logic [cgr_pkg::COLOR_W-1:0]    color_out;
	logic [cgr_pkg::CNT_W-1:0]      key_count;
	logic [cgr_pkg::STAT_W-1:0]     status;

	modport source (output valid, color_out, key_count, status, input ready);
	modport sink   (input valid, color_out, key_count, status, output ready);
endinterface

// File: hdl/cgr_ram.sv
module cgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/color_gradient_ramp.sv
// Piecewise-linear RGBA color gradient with a sorted table of up to MAX_KEYS keys.
// Items arrive on the req channel (mode, time_point, color_in, key_index) and each
// one gives exactly one item on the rsp channel (color_out, key_count, status).
// The keys live in one synchronous RAM with a registered read; an operation
// that walks the table streams through it one entry per cycle. An add walks
// down from the top entry, moving larger keys up one place; a remove walks up
// from the removed place; an evaluate walks up until it finds the first key
// not below the query. A rejected or trivial item goes straight to its result;
// a new key that goes to the front takes one more write after the walk; an
// evaluate that blends walks, then runs a restoring division for the 16-bit
// fraction, then multiplies and adds channel by channel.
// One item is worked on at a time; req.ready is high only while the block is idle.
// The result sits in an output register, so a new item may be taken while the
// previous result waits for rsp.ready; a finished result waits in its own stage
// until the output register is free, holding off further items meanwhile.
// Reset empties the table (the key count goes to zero) and clears state_q and the
// valid flags; the RAM is not cleared and is never read before being written.
module color_gradient_ramp (
	input  logic      clk,
	input  logic      arst_n,
	cgr_in_if.sink    req,
	cgr_out_if.source rsp
);
	import cgr_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_WALK = 7'b0000010,
		ST_INS  = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_MUL  = 7'b0010000,
		ST_ADD  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t             state_q;
	mode_t              op_q;
	logic [TIME_W-1:0]  tq_q;
	logic [COLOR_W-1:0] col_q;
	logic [CNT_W-1:0]   count_q;

	// Read sequencer and the stage that sees the read data.
	logic               rd_on_q;
	logic               rd_dn_q;
	logic [IDX_W-1:0]   rd_ptr_q;
	logic [IDX_W-1:0]   rd_end_q;
	logic               rv_s1;
	logic [IDX_W-1:0]   ri_s1;

	// Interpolation state.
	logic [TIME_W-1:0]  prev_t_q;
	logic [COLOR_W-1:0] prev_c_q;
	logic [COLOR_W-1:0] cr_q;
	logic [TIME_W-1:0]  span_q;
	logic [TIME_W-1:0]  rem_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [3:0]         div_cnt_q;
	logic [1:0]         ch_q;
	logic signed [25:0] prod_q;
	logic [IDX_W-1:0]   ins_pos_q;

	logic [COLOR_W-1:0] res_color_q;
	status_t            res_stat_q;

	logic               out_vld_q;
	logic [COLOR_W-1:0] out_color_q;
	logic [CNT_W-1:0]   out_cnt_q;
	logic [STAT_W-1:0]  out_stat_q;

	// RAM ports
	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [KEY_W-1:0]   wdata;
	logic [KEY_W-1:0]   rdata;
	logic [TIME_W-1:0]  rd_time;
	logic [COLOR_W-1:0] rd_color;

	logic               accept;
	logic               stop_walk;
	logic               out_load;
	logic [IDX_W-1:0]   last_idx;
	logic [TIME_W-1:0]  sat_tp;
	logic [TIME_W-1:0]  diff;
	logic [TIME_W-1:0]  span;
	logic [TIME_W:0]    rem2;
	logic               ge;
	logic [7:0]         ch_a;
	logic [7:0]         ch_b;
	logic signed [8:0]  delta;
	logic signed [25:0] prod_d;
	logic signed [25:0] sum;

	assign rd_time  = rdata[KEY_W-1:COLOR_W];
	assign rd_color = rdata[COLOR_W-1:0];
	assign last_idx = IDX_W'(count_q - CNT_W'(1));
	assign sat_tp   = sat_time(req.time_point);
	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);

	assign rsp.valid     = out_vld_q;
	assign rsp.color_out = out_color_q;
	assign rsp.key_count = out_cnt_q;
	assign rsp.status    = out_stat_q;

	cgr_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_keys (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	// The walk stops at the entry that settles the operation.
	always_comb begin
		stop_walk = 1'b0;
		if (state_q == ST_WALK && rv_s1) begin
			case (op_q)
				MODE_ADD:    stop_walk = (rd_time <= tq_q) || (ri_s1 == '0);
				MODE_REMOVE: stop_walk = (ri_s1 == last_idx);
				MODE_EVAL:   stop_walk = (tq_q <= rd_time) || (ri_s1 == last_idx);
				default:     stop_walk = 1'b1;
			endcase
		end
	end

	// Write port: moving keys during add and remove, and placing a new key.
	always_comb begin
		we    = 1'b0;
		waddr = ri_s1;
		wdata = rdata;
		case (state_q)
			ST_WALK: begin
				if (rv_s1 && op_q == MODE_ADD) begin
					we    = 1'b1;
					waddr = ri_s1 + IDX_W'(1);
					wdata = (rd_time > tq_q) ? rdata : {tq_q, col_q};
				end else if (rv_s1 && op_q == MODE_REMOVE) begin
					we    = 1'b1;
					waddr = ri_s1 - IDX_W'(1);
				end
			end
			ST_INS: begin
				we    = 1'b1;
				waddr = ins_pos_q;
				wdata = {tq_q, col_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Datapath for the fraction and the channel blend.
	always_comb begin
		diff   = tq_q - prev_t_q;
		span   = rd_time - prev_t_q;
		rem2   = {rem_q, 1'b0};
		ge     = (rem2 >= {1'b0, span_q});
		ch_a   = prev_c_q[{ch_q, 3'b000} +: 8];
		ch_b   = cr_q[{ch_q, 3'b000} +: 8];
		delta  = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
		prod_d = delta * $signed({1'b0, frac_q});
		sum    = $signed({2'b00, ch_a, 16'h0000}) + prod_q + 26'sd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_on_q   <= 1'b0;
			rv_s1     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rv_s1 <= (state_q == ST_WALK) && rd_on_q && !stop_walk;
			ri_s1 <= rd_ptr_q;

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q        <= mode_t'(req.mode);
						tq_q        <= sat_tp;
						col_q       <= req.color_in;
						case (mode_t'(req.mode))
							MODE_ADD: begin
								res_color_q <= '0;
								if (count_q == CNT_W'(MAX_KEYS)) begin
									res_stat_q <= STAT_FULL;
									state_q    <= ST_DONE;
								end else if (count_q == '0) begin
									res_stat_q <= STAT_OK;
									ins_pos_q  <= '0;
									state_q    <= ST_INS;
								end else begin
									res_stat_q <= STAT_OK;
									rd_on_q    <= 1'b1;
									rd_dn_q    <= 1'b1;
									rd_ptr_q   <= last_idx;
									rd_end_q   <= '0;
									state_q    <= ST_WALK;
								end
							end
							MODE_REMOVE: begin
								res_color_q <= '0;
								if (CNT_W'(req.key_index) >= count_q) begin
									res_stat_q <= STAT_BAD_INDEX;
									state_q    <= ST_DONE;
								end else if (IDX_W'(req.key_index) == last_idx) begin
									res_stat_q <= STAT_OK;
									count_q    <= count_q - CNT_W'(1);
									state_q    <= ST_DONE;
								end else begin
									res_stat_q <= STAT_OK;
									rd_on_q    <= 1'b1;
									rd_dn_q    <= 1'b0;
									rd_ptr_q   <= IDX_W'(req.key_index) + IDX_W'(1);
									rd_end_q   <= last_idx;
									state_q    <= ST_WALK;
								end
							end
							MODE_EVAL: begin
								if (count_q == '0) begin
									res_color_q <= BLACK_OPAQUE;
									res_stat_q  <= STAT_EMPTY;
									state_q     <= ST_DONE;
								end else begin
									res_color_q <= '0;
									res_stat_q  <= STAT_OK;
									rd_on_q     <= 1'b1;
									rd_dn_q     <= 1'b0;
									rd_ptr_q    <= '0;
									rd_end_q    <= last_idx;
									state_q     <= ST_WALK;
								end
							end
							default: begin
								res_color_q <= '0;
								res_stat_q  <= STAT_OK;
								state_q     <= ST_DONE;
							end
						endcase
					end
				end

				ST_WALK: begin
					// Issue the next read while the previous entry is examined.
					if (stop_walk) begin
						rd_on_q <= 1'b0;
					end else if (rd_on_q) begin
						if (rd_ptr_q == rd_end_q) begin
							rd_on_q <= 1'b0;
						end else if (rd_dn_q) begin
							rd_ptr_q <= rd_ptr_q - IDX_W'(1);
						end else begin
							rd_ptr_q <= rd_ptr_q + IDX_W'(1);
						end
					end

					if (rv_s1) begin
						case (op_q)
							MODE_ADD: begin
								if (rd_time <= tq_q) begin
									count_q <= count_q + CNT_W'(1);
									state_q <= ST_DONE;
								end else if (ri_s1 == '0) begin
									ins_pos_q <= '0;
									state_q   <= ST_INS;
								end
							end
							MODE_REMOVE: begin
								if (ri_s1 == last_idx) begin
									count_q <= count_q - CNT_W'(1);
									state_q <= ST_DONE;
								end
							end
							MODE_EVAL: begin
								if (tq_q <= rd_time) begin
									if (ri_s1 == '0) begin
										res_color_q <= rd_color;
										state_q     <= ST_DONE;
									end else begin
										cr_q <= rd_color;
										if (diff == span) begin
											// Query sits on the right key: fraction saturates.
											frac_q  <= '1;
											ch_q    <= 2'd3;
											state_q <= ST_MUL;
										end else begin
											rem_q     <= diff;
											span_q    <= span;
											frac_q    <= '0;
											div_cnt_q <= '0;
											state_q   <= ST_DIV;
										end
									end
								end else begin
									prev_t_q <= rd_time;
									prev_c_q <= rd_color;
									if (ri_s1 == last_idx) begin
										res_color_q <= rd_color;
										state_q     <= ST_DONE;
									end
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end

				ST_INS: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= ST_DONE;
				end

				ST_DIV: begin
					// One quotient bit per cycle; the remainder stays below the span.
					rem_q     <= ge ? TIME_W'(rem2 - {1'b0, span_q}) : rem2[TIME_W-1:0];
					frac_q    <= {frac_q[FRAC_W-2:0], ge};
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == 4'd15) begin
						ch_q    <= 2'd3;
						state_q <= ST_MUL;
					end
				end

				ST_MUL: begin
					prod_q  <= prod_d;
					state_q <= ST_ADD;
				end

				ST_ADD: begin
					res_color_q[{ch_q, 3'b000} +: 8] <= sum[23:16];
					if (ch_q == 2'd0) begin
						state_q <= ST_DONE;
					end else begin
						ch_q    <= ch_q - 2'd1;
						state_q <= ST_MUL;
					end
				end

				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_color_q <= res_color_q;
			out_cnt_q   <= count_q;
			out_stat_q  <= res_stat_q;
		end
	end
endmodule

// File: sim/tb_color_gradient_ramp.sv
`timescale 1ns / 100ps

module tb_color_gradient_ramp;
	import cgr_pkg::*;

	// The random part stops after this many items that reach the key table.
	// Items with the unused mode do not count toward it.
	localparam int RANDOM_ITEMS = 1050;
	// The receiver holds off this long so that the result stages fill up and
	// the block has to stall its request channel.
	localparam int LONG_HOLD    = 300;
	// Cycles allowed after the last expected result, beyond the longest evaluate.
	localparam int DRAIN_WAIT   = 60;
	// Upper bound on any wait for outstanding results to arrive.
	localparam int SETTLE_LIMIT = 20000;
	// Watchdog limit in ns, well above the slowest correct run.
	localparam longint TIMEOUT_NS = 6_000_000;

	typedef struct {
		logic [COLOR_W-1:0] color;
		logic [CNT_W-1:0]   count;
		status_t            status;
	} ramp_result_t;

	typedef struct {
		mode_t                   mode;
		logic signed [TPT_W-1:0] time_point;
		logic [COLOR_W-1:0]      color;
		logic [KIDX_W-1:0]       key_index;
	} ramp_request_t;

	// Shadow copy of the key table. Each accepted request updates the table
	// and queues the result that the block must give for it; each result
	// from the block is checked against the oldest queued one.
	class gradient_shadow;
		logic [TIME_W-1:0]  times [MAX_KEYS];
		logic [COLOR_W-1:0] colors [MAX_KEYS];
		int                 n_keys;
		ramp_result_t       pending [$];
		int                 n_errors;

		function new();
			n_keys   = 0;
			n_errors = 0;
		endfunction

		function void flag(string what);
			n_errors++;
			if (n_errors <= 10) begin
				$display("%0t: %s", $time, what);
			end
		endfunction

		function logic [TIME_W-1:0] clamp_time(logic signed [TPT_W-1:0] raw);
			int v;
			v = int'(raw);
			if (v < 0) begin
				return '0;
			end
			if (v > 65536) begin
				return ONE_Q16;
			end
			return v[TIME_W-1:0];
		endfunction

		// Per-channel blend with a Q0.16 weight, rounded half up.
		function logic [COLOR_W-1:0] mix(logic [COLOR_W-1:0] lo, logic [COLOR_W-1:0] hi,
				longint unsigned frac);
			longint unsigned a, b, c;
			logic [COLOR_W-1:0] res;
			res = '0;
			for (int s = 0; s < COLOR_W; s += 8) begin
				a = (lo >> s) & 8'hFF;
				b = (hi >> s) & 8'hFF;
				c = (a * (65536 - frac) + b * frac + 32768) >> 16;
				res[s +: 8] = c[7:0];
			end
			return res;
		endfunction

		function void predict(ramp_request_t req);
			ramp_result_t     r;
			logic [TIME_W-1:0] t;
			int               pos;
			bit               hit;
			longint unsigned  diff, span, frac;
			r.color  = '0;
			r.status = STAT_OK;
			case (req.mode)
			MODE_ADD: begin
				if (n_keys >= MAX_KEYS) begin
					r.status = STAT_FULL;
				end else begin
					// Equal times keep their order: the new key goes after them.
					t   = clamp_time(req.time_point);
					pos = n_keys;
					for (int i = 0; i < n_keys; i++) begin
						if (t < times[i]) begin
							pos = i;
							break;
						end
					end
					for (int i = n_keys; i > pos; i--) begin
						times[i]  = times[i-1];
						colors[i] = colors[i-1];
					end
					times[pos]  = t;
					colors[pos] = req.color;
					n_keys++;
				end
			end
			MODE_REMOVE: begin
				if (int'(req.key_index) >= n_keys) begin
					r.status = STAT_BAD_INDEX;
				end else begin
					for (int i = int'(req.key_index); i + 1 < n_keys; i++) begin
						times[i]  = times[i+1];
						colors[i] = colors[i+1];
					end
					n_keys--;
				end
			end
			MODE_EVAL: begin
				if (n_keys == 0) begin
					r.color  = BLACK_OPAQUE;
					r.status = STAT_EMPTY;
				end else begin
					t   = clamp_time(req.time_point);
					hit = 1'b0;
					for (int i = 0; i < n_keys; i++) begin
						if (t <= times[i]) begin
							hit = 1'b1;
							if (i == 0) begin
								r.color = colors[0];
							end else begin
								diff = t - times[i-1];
								span = times[i] - times[i-1];
								frac = (diff << 16) / span;
								if (frac > 65535) begin
									frac = 65535;
								end
								r.color = mix(colors[i-1], colors[i], frac);
							end
							break;
						end
					end
					if (!hit) begin
						r.color = colors[n_keys-1];
					end
				end
			end
			default: begin
			end
			endcase
			r.count = n_keys[CNT_W-1:0];
			pending.push_back(r);
		endfunction

		function void check(logic [COLOR_W-1:0] color, logic [CNT_W-1:0] count,
				logic [STAT_W-1:0] status);
			ramp_result_t e;
			if (pending.size() == 0) begin
				flag($sformatf("result with nothing expected: color %h count %0d status %0d",
					color, count, status));
				return;
			end
			e = pending.pop_front();
			if (color !== e.color || count !== e.count || status !== e.status) begin
				flag($sformatf("mismatch: color %h/%h count %0d/%0d status %0d/%0d (exp/got)",
					e.color, color, e.count, count, e.status, status));
			end
		endfunction

		function void flush_leftovers();
			while (pending.size() > 0) begin
				void'(pending.pop_front());
				flag("an expected result never came");
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	cgr_in_if  req_ch ();
	cgr_out_if rsp_ch ();

	color_gradient_ramp dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	gradient_shadow shadow = new();

	int results_seen = 0;
	int burst_left   = 0;
	// The random traffic swings between filling the table and draining it,
	// so that both the full and the empty cases come up again and again.
	bit filling      = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every result taken by the testbench is checked at the edge where it is
	// accepted. Outputs are read at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			shadow.check(rsp_ch.color_out, rsp_ch.key_count, rsp_ch.status);
			results_seen++;
		end
	end

	// Receiver: switches between stall patterns of random length, and twice
	// holds ready low for a long stretch while the sender keeps offering items.
	initial begin : receiver
		int pattern;
		int phase_left;
		int tick;
		int holds_done;
		int next_hold;
		rsp_ch.ready = 1'b0;
		pattern      = 0;
		phase_left   = 0;
		tick         = 0;
		holds_done   = 0;
		next_hold    = 150;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			tick++;
			if (holds_done < 2 && results_seen >= next_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				holds_done++;
				next_hold += 500;
			end else begin
				if (phase_left == 0) begin
					pattern    = $urandom_range(0, 3);
					phase_left = $urandom_range(20, 200);
				end
				phase_left--;
				case (pattern)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
				2: rsp_ch.ready <= (tick % 4 == 0);
				default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	// Offers one item from the next falling edge on and waits until the block
	// takes it. Valid stays high afterwards, so back-to-back items need no gap.
	task automatic send_request(ramp_request_t item);
		@(negedge clk);
		req_ch.valid      <= 1'b1;
		req_ch.mode       <= item.mode;
		req_ch.time_point <= item.time_point;
		req_ch.color_in   <= item.color;
		req_ch.key_index  <= item.key_index;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		shadow.predict(item);
	endtask

	// Sender pacing: bursts of random length with random gaps in between.
	// Now and then a burst is long, which gives stretches with no idling.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
		end
	endtask

	// Stops offering and waits until every result expected so far has come.
	task automatic wait_for_results();
		int waited;
		waited = 0;
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (shadow.pending.size() != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	function automatic ramp_request_t make_request(mode_t mode, int tp,
			logic [COLOR_W-1:0] color, int idx);
		ramp_request_t r;
		r.mode       = mode;
		r.time_point = tp[TPT_W-1:0];
		r.color      = color;
		r.key_index  = idx[KIDX_W-1:0];
		return r;
	endfunction

	// Times land often on and right next to existing key times, where the
	// search and the fraction saturation are decided, and sometimes far out
	// of range so that clamping is exercised on both sides.
	function automatic logic signed [TPT_W-1:0] random_time(bit near_keys);
		int          sel;
		int          v;
		int          k;
		logic [31:0] w;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			w = $urandom;
			v = int'(w[TPT_W-1:0]);
		end else if (sel < 14) begin
			v = 0 - int'($urandom_range(1, 131072));
		end else if (sel < 20) begin
			v = ($urandom_range(0, 1) == 1) ? 65536 : 0;
		end else if (sel < 45 && shadow.n_keys > 0) begin
			k = $urandom_range(0, shadow.n_keys - 1);
			v = int'(shadow.times[k]);
			if (near_keys) begin
				v = v + int'($urandom_range(0, 2)) - 1;
			end
		end else begin
			v = $urandom_range(0, 65536);
		end
		return v[TPT_W-1:0];
	endfunction

	function automatic logic [COLOR_W-1:0] random_color();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			return '0;
		end
		if (sel == 1) begin
			return '1;
		end
		return $urandom;
	endfunction

	function automatic ramp_request_t random_request();
		ramp_request_t r;
		int pick;
		int n;
		n = shadow.n_keys;
		// Linger at the full and empty ends for a few items before turning.
		if (filling && n == MAX_KEYS && $urandom_range(0, 3) == 0) begin
			filling = 1'b0;
		end else if (!filling && n == 0 && $urandom_range(0, 3) == 0) begin
			filling = 1'b1;
		end else if ($urandom_range(0, 49) == 0) begin
			filling = !filling;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			r.mode = MODE_NONE;
		end else if (pick < (filling ? 55 : 15)) begin
			r.mode = MODE_ADD;
		end else if (pick < (filling ? 65 : 55)) begin
			r.mode = MODE_REMOVE;
		end else begin
			r.mode = MODE_EVAL;
		end
		r.time_point = random_time(r.mode == MODE_EVAL);
		r.color      = random_color();
		// Most removes name a live key; the rest may point past the end.
		if (r.mode == MODE_REMOVE && n > 0 && $urandom_range(0, 7) != 0) begin
			r.key_index = KIDX_W'($urandom_range(0, n - 1));
		end else begin
			r.key_index = KIDX_W'($urandom_range(0, 15));
		end
		return r;
	endfunction

	// Directed opening: empty table, bad index, unused mode, clamped key times,
	// equal key times, queries on every key and between keys, a blend that
	// saturates the fraction, and a table with one key only.
	task automatic run_directed();
		ramp_request_t plan [$];
		plan.push_back(make_request(MODE_EVAL,   0,       32'h1234_5678, 0));
		plan.push_back(make_request(MODE_REMOVE, 0,       32'h0,         0));
		plan.push_back(make_request(MODE_NONE,   -1,      32'hFFFF_FFFF, 15));
		plan.push_back(make_request(MODE_ADD,    -131072, 32'hFF00_0080, 0));
		plan.push_back(make_request(MODE_ADD,    131071,  32'h00FF_00FF, 0));
		plan.push_back(make_request(MODE_ADD,    32768,   32'h0000_FF00, 0));
		plan.push_back(make_request(MODE_ADD,    32768,   32'hFFFF_FFFF, 0));
		plan.push_back(make_request(MODE_EVAL,   -131072, 32'h0,         0));
		plan.push_back(make_request(MODE_EVAL,   131071,  32'h0,         0));
		plan.push_back(make_request(MODE_EVAL,   16384,   32'h0,         0));
		plan.push_back(make_request(MODE_EVAL,   32768,   32'h0,         0));
		plan.push_back(make_request(MODE_EVAL,   49152,   32'h0,         0));
		plan.push_back(make_request(MODE_EVAL,   1,       32'h0,         0));
		plan.push_back(make_request(MODE_REMOVE, 0,       32'h0,         15));
		plan.push_back(make_request(MODE_REMOVE, 0,       32'h0,         4));
		plan.push_back(make_request(MODE_REMOVE, 0,       32'h0,         1));
		plan.push_back(make_request(MODE_ADD,    65537,   32'h0000_0000, 0));
		plan.push_back(make_request(MODE_EVAL,   65535,   32'h0,         0));
		repeat (4) plan.push_back(make_request(MODE_REMOVE, 0, 32'h0, 0));
		plan.push_back(make_request(MODE_ADD,    1000,    32'h1234_5678, 0));
		plan.push_back(make_request(MODE_EVAL,   60000,   32'h0,         0));
		plan.push_back(make_request(MODE_EVAL,   500,     32'h0,         0));
		plan.push_back(make_request(MODE_REMOVE, 0,       32'h0,         0));
		foreach (plan[i]) begin
			pace_sender();
			send_request(plan[i]);
		end
	endtask

	initial begin : stimulus
		ramp_request_t item;
		int sent;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.mode       = MODE_NONE;
		req_ch.time_point = '0;
		req_ch.color_in   = '0;
		req_ch.key_index  = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		// The sender pauses here until every directed result is back.
		wait_for_results();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			item = random_request();
			pace_sender();
			send_request(item);
			if (item.mode != MODE_NONE) begin
				sent++;
				if (sent == RANDOM_ITEMS / 2) begin
					wait_for_results();
				end
			end
		end

		wait_for_results();
		repeat (DRAIN_WAIT) @(posedge clk);
		shadow.flush_leftovers();
		if (shadow.n_errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
hdl/cgr_pkg.sv
hdl/cgr_in_if.sv
hdl/cgr_out_if.sv
hdl/cgr_ram.sv
hdl/color_gradient_ramp.sv
sim/tb_color_gradient_ramp.sv
